FILE: src/channel_window_credit_control_unit_macros.svh
`ifndef CHANNEL_WINDOW_CREDIT_CONTROL_UNIT_MACROS_SVH
`define CHANNEL_WINDOW_CREDIT_CONTROL_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CWCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwcc assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CWCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwcc assertion failed");

`endif

FILE: src/cwcc_pkg.sv
package cwcc_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_OPEN_CONFIRM = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DATA_IN      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DATA_OUT     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADJUST_IN    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ADJUST_OUT   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_MALFORMED = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERRUN   = 3'd2;
  localparam logic [STAT_W-1:0] ST_WAIT      = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FULL_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ID  = 2'd3;

  localparam logic [WORD_W-1:0] FULL_WINDOW_RST = 32'd2097152;
  localparam logic [WORD_W-1:0] LOW_MARK_RST    = 32'd1048576;
  localparam logic [WORD_W-1:0] MAX_PAYLOAD_RST = 32'd32768;
  localparam logic [WORD_W-1:0] CHANNEL_ID_RST  = 32'd0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] recipient;
    logic [WORD_W-1:0] amount;
    logic [WORD_W-1:0] peer_max_packet;
    logic              well_formed;
  } event_t;

  typedef struct packed {
    logic [WORD_W-1:0] full_window;
    logic [WORD_W-1:0] low_mark;
    logic [WORD_W-1:0] max_payload;
    logic [WORD_W-1:0] local_channel_id;
  } cfg_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] local_window_now;
    logic [WORD_W-1:0] remote_window_now;
    logic              refill_due;
    logic [WORD_W-1:0] suggested_increment;
  } result_t;

  typedef struct packed {
    logic [WORD_W-1:0] rx_credit;
    logic [WORD_W-1:0] tx_credit;
  } window_t;

endpackage

FILE: src/cwcc_in_stage.sv
module cwcc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cwcc_pkg::event_t  in_event,
  input  logic              advance,
  output logic              evt_valid,
  output cwcc_pkg::event_t  evt
);

  logic             vld_r;
  logic             vld_nxt;
  cwcc_pkg::event_t evt_r;
  logic             accept;

  assign in_stall  = vld_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign vld_nxt   = accept ? 1'b1 : (advance ? 1'b0 : vld_r);
  assign evt_valid = vld_r;
  assign evt       = evt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      evt_r <= in_event;
    end
  end

endmodule

FILE: src/cwcc_core.sv
module cwcc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               commit,
  input  cwcc_pkg::event_t   evt,
  input  cwcc_pkg::cfg_t     cfg,
  output cwcc_pkg::result_t  res,
  output cwcc_pkg::window_t  win
);

  logic [cwcc_pkg::WORD_W-1:0] lw_r, lw_nxt;
  logic [cwcc_pkg::WORD_W-1:0] rw_r, rw_nxt;
  logic [cwcc_pkg::WORD_W-1:0] rmp_r, rmp_nxt;
  logic [cwcc_pkg::STAT_W-1:0] status;
  logic                        msg_bad;
  logic [cwcc_pkg::WORD_W:0]   rw_sum;
  logic [cwcc_pkg::WORD_W:0]   lw_sum;
  logic                        due;

  assign msg_bad = !evt.well_formed || (evt.recipient != cfg.local_channel_id);
  assign rw_sum  = {1'b0, rw_r} + {1'b0, evt.amount};
  assign lw_sum  = {1'b0, lw_r} + {1'b0, evt.amount};

  always_comb begin
    status  = cwcc_pkg::ST_OK;
    lw_nxt  = lw_r;
    rw_nxt  = rw_r;
    rmp_nxt = rmp_r;
    case (evt.kind)
      cwcc_pkg::KIND_OPEN_CONFIRM: begin
        if (msg_bad || evt.peer_max_packet == '0) begin
          status = cwcc_pkg::ST_MALFORMED;
        end else begin
          rw_nxt  = evt.amount;
          rmp_nxt = (evt.peer_max_packet > cfg.max_payload) ? cfg.max_payload
                                                            : evt.peer_max_packet;
        end
      end
      cwcc_pkg::KIND_DATA_IN: begin
        if (msg_bad || evt.amount > cfg.max_payload) begin
          status = cwcc_pkg::ST_MALFORMED;
        end else if (evt.amount > lw_r) begin
          status = cwcc_pkg::ST_OVERRUN;
        end else begin
          lw_nxt = lw_r - evt.amount;
        end
      end
      cwcc_pkg::KIND_DATA_OUT: begin
        if (evt.amount > rw_r || evt.amount > rmp_r) begin
          status = cwcc_pkg::ST_WAIT;
        end else begin
          rw_nxt = rw_r - evt.amount;
        end
      end
      cwcc_pkg::KIND_ADJUST_IN: begin
        if (msg_bad) begin
          status = cwcc_pkg::ST_MALFORMED;
        end else if (rw_sum[cwcc_pkg::WORD_W]) begin
          status = cwcc_pkg::ST_RANGE;
        end else begin
          rw_nxt = rw_sum[cwcc_pkg::WORD_W-1:0];
        end
      end
      cwcc_pkg::KIND_ADJUST_OUT: begin
        if (evt.amount == '0) begin
          status = cwcc_pkg::ST_MALFORMED;
        end else if (lw_sum[cwcc_pkg::WORD_W]) begin
          status = cwcc_pkg::ST_RANGE;
        end else begin
          lw_nxt = lw_sum[cwcc_pkg::WORD_W-1:0];
        end
      end
      default: begin
        status = cwcc_pkg::ST_MALFORMED;
      end
    endcase
  end

  assign due = (lw_nxt <= cfg.low_mark);

  always_comb begin
    res.status              = status;
    res.local_window_now    = lw_nxt;
    res.remote_window_now   = rw_nxt;
    res.refill_due          = due;
    res.suggested_increment = (due && cfg.full_window > lw_nxt) ? cfg.full_window - lw_nxt
                                                                : '0;
  end

  assign win.rx_credit = lw_r;
  assign win.tx_credit = rw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r  <= cwcc_pkg::FULL_WINDOW_RST;
      rw_r  <= '0;
      rmp_r <= '0;
    end else if (commit) begin
      lw_r  <= lw_nxt;
      rw_r  <= rw_nxt;
      rmp_r <= rmp_nxt;
    end
  end

endmodule

FILE: src/channel_window_credit_control_unit.sv
// Result path: the input-stage register, then the result register. Throughput:
// one event per cycle while the output is not stalled; the window registers update
// in the same cycle that the result register loads, so back-to-back events see fresh state.
// Reset (rst_n low, synchronous): pipeline empties, windows return to
// local 2097152 / remote 0, and all configuration registers to their defaults.
`include "channel_window_credit_control_unit_macros.svh"

module channel_window_credit_control_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cwcc_pkg::KIND_W-1:0]   in_kind,
  input  logic [cwcc_pkg::WORD_W-1:0]   in_recipient,
  input  logic [cwcc_pkg::WORD_W-1:0]   in_amount,
  input  logic [cwcc_pkg::WORD_W-1:0]   in_peer_max_packet,
  input  logic                          in_well_formed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cwcc_pkg::STAT_W-1:0]   out_status,
  output logic [cwcc_pkg::WORD_W-1:0]   out_local_window_now,
  output logic [cwcc_pkg::WORD_W-1:0]   out_remote_window_now,
  output logic                          out_refill_due,
  output logic [cwcc_pkg::WORD_W-1:0]   out_suggested_increment,
  input  logic                          cfg_we,
  input  logic [cwcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwcc_pkg::WORD_W-1:0]   cfg_wdata
);

  cwcc_pkg::event_t  in_event;
  cwcc_pkg::event_t  evt;
  cwcc_pkg::cfg_t    cfg_r;
  cwcc_pkg::result_t res;
  cwcc_pkg::result_t res_r;
  cwcc_pkg::window_t win;
  logic              evt_valid;
  logic              advance;
  logic              commit;
  logic              out_valid_r;
  logic              out_valid_nxt;

  assign in_event.kind            = in_kind;
  assign in_event.recipient       = in_recipient;
  assign in_event.amount          = in_amount;
  assign in_event.peer_max_packet = in_peer_max_packet;
  assign in_event.well_formed     = in_well_formed;

  assign advance       = !out_valid_r || !out_stall;
  assign commit        = evt_valid && advance;
  assign out_valid_nxt = advance ? commit : out_valid_r;

  cwcc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_event  (in_event),
    .advance   (advance),
    .evt_valid (evt_valid),
    .evt       (evt)
  );

  cwcc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .evt    (evt),
    .cfg    (cfg_r),
    .res    (res),
    .win    (win)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_window      <= cwcc_pkg::FULL_WINDOW_RST;
      cfg_r.low_mark         <= cwcc_pkg::LOW_MARK_RST;
      cfg_r.max_payload      <= cwcc_pkg::MAX_PAYLOAD_RST;
      cfg_r.local_channel_id <= cwcc_pkg::CHANNEL_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cwcc_pkg::REG_FULL_WINDOW: cfg_r.full_window      <= cfg_wdata;
        cwcc_pkg::REG_LOW_MARK:    cfg_r.low_mark         <= cfg_wdata;
        cwcc_pkg::REG_MAX_PAYLOAD: cfg_r.max_payload      <= cfg_wdata;
        cwcc_pkg::REG_CHANNEL_ID:  cfg_r.local_channel_id <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = res_r.status;
  assign out_local_window_now    = res_r.local_window_now;
  assign out_remote_window_now   = res_r.remote_window_now;
  assign out_refill_due          = res_r.refill_due;
  assign out_suggested_increment = res_r.suggested_increment;

  // a rejected event leaves both windows untouched
  `CWCC_ASSERT_NEXT(a_reject_keeps_windows, commit && res.status != cwcc_pkg::ST_OK, win == $past(win))
  // the input side backs up only when both stages are full and the output is stalled
  `CWCC_ASSERT_NOW(a_stall_only_when_full, in_stall, evt_valid && out_valid_r && out_stall)
  // no refill increment is suggested unless a refill is due
  `CWCC_ASSERT_NOW(a_inc_needs_due, out_valid_r && !out_refill_due, out_suggested_increment == '0)

endmodule
